### design/swlse_pkg.sv
package swlse_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_BYTES   = 2'd0,
    CFG_OBJ_SPAN      = 2'd1,
    CFG_SLOTS_PER_OBJ = 2'd2,
    CFG_OWN_OBJECT    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_INVAL = 2'd2,
    REQ_OTHER = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_TAKEN   = 2'd1,
    ST_INVALID = 2'd2,
    ST_SPARE   = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_UNWRITTEN = 3'd1,
    RS_INVALID   = 3'd2,
    RS_EXISTS    = 3'd3,
    RS_TOO_LARGE = 3'd4,
    RS_VALID     = 3'd5,
    RS_WRONG_OBJ = 3'd6,
    RS_BAD_SETUP = 3'd7
  } status_t;

  // Command word passed from the mapping front end to the slot back end.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] payload_length;
    logic        force_flag;
    logic        bad_setup;
    logic        wrong_obj;
    logic [9:0]  slot_index;
    logic [25:0] byte_offset;
    logic [16:0] slot_bytes;
    logic [15:0] slot_full;
  } cmd_t;

endpackage

### design/swlse_if.sv
interface swlse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] log_position;
  logic [15:0] payload_length;
  logic        force_flag;
  modport source (output valid, req_type, log_position, payload_length, force_flag,
                  input ready);
  modport sink (input valid, req_type, log_position, payload_length, force_flag,
                output ready);
endinterface

interface swlse_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot_index;
  logic [25:0] byte_offset;
  logic [16:0] slot_bytes;
  modport source (output valid, status, slot_index, byte_offset, slot_bytes,
                  input ready);
  modport sink (input valid, status, slot_index, byte_offset, slot_bytes,
                output ready);
endinterface

### design/swlse_div.sv
// Radix-2 restoring divider, 64-bit dividend, one quotient bit a cycle.
module swlse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [15:0] rem
);
  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [63:0] q_r;
  logic [15:0] rem_r;
  logic [15:0] d_r;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem_r, q_r[63]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[15:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;
endmodule

### design/swlse_front.sv
// Maps a log position to slot, offset and object; two divisions on a shared divider.
module swlse_front (
  input  logic                 clk,
  input  logic                 rst_n,
  swlse_in_if.sink             in_ch,
  input  logic [15:0]          entry_bytes,
  input  logic [15:0]          objs_per_stripe,
  input  logic [10:0]          slots_per_object,
  input  logic [63:0]          own_object_number,
  input  logic [10:0]          max_slots,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output swlse_pkg::cmd_t      cmd
);
  import swlse_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_DIV1, F_DIV2, F_MUL1, F_MUL2, F_PUSH} fstate_t;

  fstate_t     state_r;
  cmd_t        cmd_r;
  logic [63:0] pos_rem_r;
  logic [63:0] stripe_r;
  logic [63:0] prod_r;
  logic [31:0] prod_hi_r;
  logic        div_start;
  logic [63:0] div_a;
  logic [15:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic [15:0] div_r;
  logic        bad;
  logic [16:0] sbytes;

  assign bad = (entry_bytes == 16'd0) || (objs_per_stripe == 16'd0) ||
               (slots_per_object == 11'd0) || (slots_per_object > max_slots);
  assign sbytes = {1'b0, entry_bytes} + 17'd1;

  assign in_ch.ready = (state_r == F_IDLE);
  assign cmd_valid   = (state_r == F_PUSH);
  assign cmd         = cmd_r;

  always_comb begin
    div_start = 1'b0;
    div_a     = in_ch.log_position;
    div_b     = objs_per_stripe;
    if (state_r == F_IDLE && in_ch.valid && !bad) div_start = 1'b1;
    if (state_r == F_DIV1 && div_done) begin
      div_start = 1'b1;
      div_a     = div_q;
      div_b     = {5'd0, slots_per_object};
    end
  end

  swlse_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            cmd_r.req_type       <= in_ch.req_type;
            cmd_r.payload_length <= in_ch.payload_length;
            cmd_r.force_flag     <= in_ch.force_flag;
            cmd_r.bad_setup      <= bad;
            cmd_r.wrong_obj      <= 1'b0;
            cmd_r.slot_index     <= '0;
            cmd_r.byte_offset    <= '0;
            cmd_r.slot_bytes     <= '0;
            cmd_r.slot_full      <= '0;
            state_r <= bad ? F_PUSH : F_DIV1;
          end
        end
        F_DIV1: begin
          if (div_done) begin
            stripe_r  <= div_q;
            pos_rem_r <= {48'd0, div_r};
            state_r   <= F_DIV2;
          end
        end
        F_DIV2: begin
          if (div_done) begin
            cmd_r.slot_full  <= div_r;
            cmd_r.slot_index <= div_r[9:0];
            cmd_r.slot_bytes <= sbytes;
            stripe_r         <= div_q;
            state_r          <= F_MUL1;
          end
        end
        F_MUL1: begin
          // object quotient times stripe span, as two 32-bit halves (low 64 bits kept)
          prod_r    <= {32'd0, stripe_r[31:0]} * {48'd0, objs_per_stripe};
          prod_hi_r <= stripe_r[63:32] * {16'd0, objs_per_stripe};
          cmd_r.byte_offset <= 26'(cmd_r.slot_full * sbytes);
          state_r <= F_MUL2;
        end
        F_MUL2: begin
          cmd_r.wrong_obj <= (prod_r + {prod_hi_r, 32'd0} + pos_rem_r) !=
                             own_object_number;
          state_r         <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

### design/swlse_queue.sv
// Two-entry command queue between mapping front end and slot back end.
module swlse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  swlse_pkg::cmd_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output swlse_pkg::cmd_t pop_data
);
  import swlse_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

### design/swlse_back.sv
// Applies slot-state rules; state memory with clearing pass after reset.
module swlse_back #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  swlse_pkg::cmd_t cmd,
  swlse_out_if.source     out_ch
);
  import swlse_pkg::*;

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_OUT} bstate_t;

  bstate_t      state_r;
  logic [1:0]   mem [MAX_SLOTS];
  logic [AW-1:0] clr_r;
  logic [AW-1:0] addr_r;
  logic [1:0]   rd_r;
  cmd_t         c_r;
  logic         we;
  logic [AW-1:0] wa;
  logic [1:0]   wd;
  status_t      st_res;
  logic         out_v_r;
  logic [2:0]   status_r;
  logic [9:0]   slot_r;
  logic [25:0]  off_r;
  logic [16:0]  sb_r;
  slot_st_t     hdr;
  logic         res_fire;

  assign cmd_ready = (state_r == B_IDLE);
  // result register is free or empties this cycle
  assign res_fire  = (state_r == B_OUT) && (!out_v_r || out_ch.ready);

  always_comb begin
    we     = 1'b0;
    wa     = addr_r;
    wd     = ST_UNUSED;
    st_res = RS_OK;
    hdr    = c_r.force_flag ? ST_UNUSED : slot_st_t'(rd_r);
    if (state_r == B_CLEAR) begin
      we = 1'b1;
      wa = clr_r;
    end else if (c_r.bad_setup) begin
      st_res = RS_BAD_SETUP;
    end else if (c_r.wrong_obj) begin
      st_res = RS_WRONG_OBJ;
    end else begin
      case (req_t'(c_r.req_type))
        REQ_WRITE: begin
          if (rd_r != ST_UNUSED) st_res = RS_EXISTS;
          else if ({1'b0, c_r.payload_length} + 17'd1 > c_r.slot_bytes)
            st_res = RS_TOO_LARGE;
          else begin
            st_res = RS_OK; we = res_fire; wd = ST_TAKEN;
          end
        end
        REQ_INVAL: begin
          if (hdr == ST_INVALID) st_res = RS_OK;
          else if (hdr == ST_UNUSED) begin
            st_res = RS_OK; we = res_fire; wd = ST_INVALID;
          end else st_res = RS_VALID;
        end
        default: begin
          if (rd_r == ST_TAKEN) st_res = RS_OK;
          else if (rd_r == ST_UNUSED) st_res = RS_UNWRITTEN;
          else st_res = RS_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (res_fire) out_v_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_SLOTS - 1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          if (cmd_valid) begin
            c_r     <= cmd;
            addr_r  <= AW'(cmd.slot_full);
            state_r <= B_READ;
          end
        end
        B_READ: state_r <= B_OUT;
        B_OUT: begin
          if (res_fire) begin
            status_r <= st_res;
            slot_r   <= c_r.slot_index;
            off_r    <= c_r.byte_offset;
            sb_r     <= c_r.slot_bytes;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = status_r;
  assign out_ch.slot_index  = slot_r;
  assign out_ch.byte_offset = off_r;
  assign out_ch.slot_bytes  = sb_r;
endmodule

### design/striped_write_once_log_slot_engine.sv
// Slot engine for one stripe object of a write-once log.
// in_*  : request words (req_type, log_position, payload_length, force_flag),
//         valid/ready; accepted when both high.
// out_* : one result word per request (status, slot_index, byte_offset,
//         slot_bytes), valid/ready through an output register.
// cfg_* : write port; index 0 entry_bytes, 1 objects per stripe, 2 slots_per_object,
//         3 own_object_number. Write only while idle.
// After accept: two 64-step radix-2 divisions on one shared divider (position /
// objects per stripe, then stripe / slots_per_object), then the multiply and
// compare states, a push into the queue, then the read and output states of the
// back end. The front end is busy from accept until its push and takes no new
// request before then. Bad setup requests skip the divider and the multiply and
// compare states and go straight to the push.
// A 2-word queue lets the front end map the next request while the back end
// waits on a stalled receiver.
// Reset: configuration registers clear to 0; the back end then sweeps the
// slot-state memory to unused, one slot a cycle. Requests can be accepted and
// mapped meanwhile but results appear only after the sweep.
// A stalled receiver holds the result; the back end, then the queue, then
// the front end fill up and in_ready stays low.
module striped_write_once_log_slot_engine #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  swlse_in_if.sink                            in_ch,
  swlse_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [swlse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swlse_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swlse_pkg::*;

  logic [15:0] entry_bytes_r;
  logic [15:0] objs_per_stripe_r;
  logic [10:0] slots_per_object_r;
  logic [63:0] own_object_r;
  logic        f_valid, f_ready, q_valid, q_ready;
  cmd_t        f_cmd, q_cmd;
  logic [10:0] max_slots;

  // slots_per_object above this bound is a bad setup
  assign max_slots = (MAX_SLOTS > 2047) ? 11'h7FF : 11'(MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_bytes_r      <= '0;
      objs_per_stripe_r  <= '0;
      slots_per_object_r <= '0;
      own_object_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENTRY_BYTES:   entry_bytes_r      <= cfg_data[15:0];
        CFG_OBJ_SPAN:      objs_per_stripe_r  <= cfg_data[15:0];
        CFG_SLOTS_PER_OBJ: slots_per_object_r <= cfg_data[10:0];
        CFG_OWN_OBJECT:    own_object_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  swlse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .entry_bytes(entry_bytes_r), .objs_per_stripe(objs_per_stripe_r),
    .slots_per_object(slots_per_object_r), .own_object_number(own_object_r),
    .max_slots(max_slots),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  swlse_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_cmd),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_cmd)
  );

  swlse_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_ch(out_ch)
  );
endmodule

### design/swlse_checker.sv
module swlse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [9:0]  out_slot_index,
  input logic [25:0] out_byte_offset,
  input logic [16:0] out_slot_bytes
);
  import swlse_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == RS_BAD_SETUP |-> out_slot_index == 10'd0 &&
    out_byte_offset == 26'd0 && out_slot_bytes == 17'd0)
    else $error("bad setup fields nonzero");
  a_sb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != RS_BAD_SETUP |-> out_slot_bytes != 17'd0)
    else $error("slot size zero");
endmodule

bind striped_write_once_log_slot_engine swlse_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_slot_index(out_ch.slot_index),
  .out_byte_offset(out_ch.byte_offset), .out_slot_bytes(out_ch.slot_bytes)
);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import swlse_pkg::*;

  localparam int unsigned SLOT_CNT = 1024;

  // Scoreboard: shadow slot states and registers, queue of expected results.
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [25:0] byte_offset;
    logic [16:0] slot_bytes;
  } result_t;

  class slot_scoreboard;
    logic [15:0] entry_bytes;
    logic [15:0] objs_per_stripe;
    logic [10:0] slots_per_obj;
    logic [63:0] own_object;
    slot_st_t    slot_st[SLOT_CNT];
    result_t     pending[$];
    int          errors;

    function new();
      entry_bytes = '0;
      objs_per_stripe = '0;
      slots_per_obj = '0;
      own_object = '0;
      errors = 0;
      foreach (slot_st[i]) slot_st[i] = ST_UNUSED;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_ENTRY_BYTES:   entry_bytes = val[15:0];
        CFG_OBJ_SPAN:      objs_per_stripe = val[15:0];
        CFG_SLOTS_PER_OBJ: slots_per_obj = val[10:0];
        CFG_OWN_OBJECT:    own_object = val;
        default: ;
      endcase
    endfunction

    function void note_request(req_t req, logic [63:0] pos, logic [15:0] plen,
                               logic frc);
      result_t     r;
      logic [63:0] stripe, slot, objno, sbytes, offset;
      slot_st_t    st, hdr;
      r = '0;
      if (entry_bytes == 0 || objs_per_stripe == 0 || slots_per_obj == 0 ||
          slots_per_obj > SLOT_CNT) begin
        r.status = RS_BAD_SETUP;
        pending.push_back(r);
        return;
      end
      stripe = pos / objs_per_stripe;
      slot = stripe % slots_per_obj;
      objno = (stripe / slots_per_obj) * objs_per_stripe + pos % objs_per_stripe;
      sbytes = 64'd1 + entry_bytes;
      offset = slot * sbytes;
      r.slot_index = slot[9:0];
      r.byte_offset = offset[25:0];
      r.slot_bytes = sbytes[16:0];
      if (objno != own_object) begin
        r.status = RS_WRONG_OBJ;
        pending.push_back(r);
        return;
      end
      st = slot_st[slot];
      case (req)
        REQ_WRITE: begin
          if (st != ST_UNUSED) r.status = RS_EXISTS;
          else if ({48'd0, plen} + 64'd1 > sbytes) r.status = RS_TOO_LARGE;
          else begin
            slot_st[slot] = ST_TAKEN;
            r.status = RS_OK;
          end
        end
        REQ_INVAL: begin
          hdr = frc ? ST_UNUSED : st;
          if (hdr == ST_INVALID) r.status = RS_OK;
          else if (hdr == ST_UNUSED) begin
            slot_st[slot] = ST_INVALID;
            r.status = RS_OK;
          end else r.status = RS_VALID;
        end
        default: begin
          if (st == ST_TAKEN) r.status = RS_OK;
          else if (st == ST_UNUSED) r.status = RS_UNWRITTEN;
          else r.status = RS_INVALID;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result word status=%0d", got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status exp=%0d act=%0d", exp.status, got.status);
        errors++;
      end
      if (got.slot_index !== exp.slot_index) begin
        $error("slot_index exp=%0d act=%0d", exp.slot_index, got.slot_index);
        errors++;
      end
      if (got.byte_offset !== exp.byte_offset) begin
        $error("byte_offset exp=%0d act=%0d", exp.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.slot_bytes !== exp.slot_bytes) begin
        $error("slot_bytes exp=%0d act=%0d", exp.slot_bytes, got.slot_bytes);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  swlse_in_if  in_ch();
  swlse_out_if out_ch();

  striped_write_once_log_slot_engine DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slot_scoreboard sb = new();

  int send_idle_pct = 0;   // sender gap chance, percent
  int recv_idle_pct = 0;   // receiver stall chance, percent
  int hold_cycles = 0;     // long receiver hold-off, counted by the sink
  longint cycle_cnt = 0;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.log_position = '0;
    in_ch.payload_length = '0;
    in_ch.force_flag = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink: random stalls plus an optional long hold-off. Sampled words
  // are checked at the edge where valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.slot_index, out_ch.byte_offset,
                       out_ch.slot_bytes});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_cfg(cfg_idx_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_layout(logic [15:0] eb, logic [15:0] sw, logic [10:0] spo,
                            logic [63:0] own);
    write_cfg(CFG_ENTRY_BYTES, eb);
    write_cfg(CFG_OBJ_SPAN, sw);
    write_cfg(CFG_SLOTS_PER_OBJ, spo);
    write_cfg(CFG_OWN_OBJECT, own);
  endtask

  // Offer one word; valid stays up until it is taken.
  task automatic send_req(req_t req, logic [63:0] pos, logic [15:0] plen,
                          logic frc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.log_position <= pos;
    in_ch.payload_length <= plen;
    in_ch.force_flag <= frc;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req, pos, plen, frc);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected word has come back, then let the block settle.
  task automatic drain();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Position that maps into the own object: pick stripe row and column.
  function automatic logic [63:0] own_pos(int unsigned slot);
    logic [63:0] obj, row, col;
    obj = sb.own_object;
    row = obj / sb.objs_per_stripe;
    col = obj % sb.objs_per_stripe;
    return ((row * sb.slots_per_obj) + slot) * sb.objs_per_stripe + col;
  endfunction

  // Random request, mostly aimed at the own object's slots.
  task automatic rand_req();
    logic [63:0] pos;
    logic [15:0] plen;
    req_t        req;
    req = req_t'($urandom_range(3));
    if ($urandom_range(9) < 8)
      pos = own_pos($urandom_range(sb.slots_per_obj - 1));
    else
      pos = {$urandom, $urandom};
    case ($urandom_range(3))
      0: plen = {$urandom} & 16'hFFFF;
      1: plen = sb.entry_bytes;
      2: plen = sb.entry_bytes + 16'd1;
      default: plen = $urandom_range(sb.entry_bytes);
    endcase
    send_req(req, pos, plen, $urandom_range(1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: all registers zero, bad setup for any request.
    send_req(REQ_READ, 64'd0, 16'd0, 1'b0);
    send_req(REQ_WRITE, '1, 16'hFFFF, 1'b1);
    drain();

    // Entry bytes, slots per object and objects per stripe zero in turn, and slots above the limit.
    set_layout(16'd0, 16'd4, 11'd8, 64'd0);
    send_req(REQ_READ, 64'd5, 16'd0, 1'b0);
    drain();
    set_layout(16'd8, 16'd4, 11'd0, 64'd0);
    send_req(REQ_READ, 64'd5, 16'd0, 1'b0);
    drain();
    set_layout(16'd8, 16'd4, 11'd1025, 64'd0);
    send_req(REQ_INVAL, 64'd5, 16'd0, 1'b0);
    drain();
    set_layout(16'd8, 16'd0, 11'd8, 64'd0);
    send_req(REQ_WRITE, 64'd5, 16'd1, 1'b0);
    drain();

    // Small layout: slot rules on the own object.
    set_layout(16'd8, 16'd4, 11'd8, 64'd1);
    send_req(REQ_READ, own_pos(0), 16'd0, 1'b0);     // unwritten
    send_req(REQ_WRITE, own_pos(0), 16'd9, 1'b0);    // too large
    send_req(REQ_WRITE, own_pos(0), 16'd8, 1'b0);    // ok at limit
    send_req(REQ_WRITE, own_pos(0), 16'd0, 1'b0);    // exists
    send_req(REQ_READ, own_pos(0), 16'd0, 1'b0);     // ok
    send_req(REQ_INVAL, own_pos(0), 16'd0, 1'b0);    // valid, no change
    send_req(REQ_INVAL, own_pos(0), 16'd0, 1'b1);    // forced
    send_req(REQ_READ, own_pos(0), 16'd0, 1'b0);     // invalid
    send_req(REQ_INVAL, own_pos(0), 16'd0, 1'b0);    // already invalid
    send_req(REQ_INVAL, own_pos(1), 16'd0, 1'b0);    // unused -> invalid
    send_req(REQ_WRITE, own_pos(1), 16'd0, 1'b0);    // exists
    send_req(REQ_OTHER, own_pos(2), 16'd0, 1'b0);    // treated as read
    send_req(REQ_READ, 64'd0, 16'd0, 1'b0);          // wrong object
    send_req(REQ_READ, '1, 16'd0, 1'b0);
    drain();

    // Extremes: largest registers, full slot range, top object number.
    set_layout(16'hFFFF, 16'hFFFF, 11'd1024, '1);
    send_req(REQ_WRITE, own_pos(1023), 16'hFFFF, 1'b0);
    send_req(REQ_READ, own_pos(1023), 16'd0, 1'b0);
    send_req(REQ_READ, '1, 16'd0, 1'b0);
    drain();

    // Random phases across layouts and idling profiles.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 33; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: set_layout(16'd3, 16'd2, 11'd16, 64'd3);
        1: set_layout(16'd1, 16'd1, 11'd1, 64'd0);
        2: set_layout($urandom_range(1, 300), $urandom_range(1, 9),
                      $urandom_range(1, 64), $urandom_range(0, 40));
        3: set_layout(16'hFFFF, 16'd7, 11'd1024, 64'd5);
        4: set_layout(16'd20, 16'hFFFF, 11'd32, {$urandom, $urandom});
        default: set_layout($urandom_range(1, 65535), $urandom_range(1, 65535),
                            $urandom_range(1, 1024), {$urandom, $urandom});
      endcase
      if (ph == 2) hold_cycles = 3000;  // force back-pressure into the input
      for (int n = 0; n < 200; n++) rand_req();
      drain();
    end

    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
design/swlse_pkg.sv
design/swlse_if.sv
design/swlse_div.sv
design/swlse_front.sv
design/swlse_queue.sv
design/swlse_back.sv
design/striped_write_once_log_slot_engine.sv
design/swlse_checker.sv
sim/tb.sv
